// File: rtl/aes256_cbc_encryptor_macros.svh
// assertion macros for the encryptor
`ifndef AES256_CBC_ENCRYPTOR_MACROS_SVH
`define AES256_CBC_ENCRYPTOR_MACROS_SVH

// property that holds when not in reset
`define AES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every clock edge, also during reset
`define AES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/aescbc_pkg.sv
`default_nettype none
package aescbc_pkg;

  localparam int unsigned NumRounds   = 14;
  localparam int unsigned NumKeyWords = 60;
  localparam int unsigned KeyIdxW     = 6;
  localparam int unsigned RoundW      = 4;
  localparam int unsigned CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegKey0  = 3'd0,
    RegKey1  = 3'd1,
    RegKey2  = 3'd2,
    RegKey3  = 3'd3,
    RegIvHi  = 3'd4,
    RegIvLo  = 3'd5
  } cfg_reg_e;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StExpand = 5'b00010,
    StLoad   = 5'b00100,
    StRound  = 5'b01000,
    StOut    = 5'b10000
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // subbytes, shiftrows, and optionally mixcolumns; byte 0 at [127:120]
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic do_mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[c*4+k] = SBOX[b[((c+k)%4)*4+k]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      if (do_mix) begin
        t[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    round_fn = r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/aes256_cbc_encryptor.sv
// AES-256 CBC encryptor, one 128-bit block per request.
// Input channel: block_high_i/block_low_i/byte_count_i with in_valid_i/in_ready_o.
// byte_count below 16 pads the block PKCS#7 style and ends the message; the chain
// then returns to the IV. Counts above 16 act as 16.
// Output channel: cipher_high_o/cipher_low_o/last_o with out_valid_o/out_ready_i.
// Config: cfg_we_i, cfg_idx_i, cfg_data_i: key words 0..3, then IV high, IV low.
// A key write forces key expansion on the next block; an IV write loads the chain.
// A request passes through a load state and then the round states, which share one
// round unit; when the key must be expanded, an expansion state comes first and
// computes one key word per cycle through the key schedule S-box word.
// in_ready_o returns only in the cycle after the result is taken.
// The block takes one request at a time; in_ready_o is low from accept until the
// result is taken, so a stalled receiver holds the result and the input.
// Reset clears the key, IV, chain and key-valid flag; round keys are recomputed
// before first use.
`default_nettype none
`include "aes256_cbc_encryptor_macros.svh"
module aes256_cbc_encryptor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [63:0]  block_high_i,
  input  wire logic [63:0]  block_low_i,
  input  wire logic [4:0]   byte_count_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [63:0]       cipher_high_o,
  output logic [63:0]       cipher_low_o,
  output logic              last_o
);

  aescbc_pkg::state_e state_q, state_d;
  logic [255:0] key_q;
  logic [127:0] iv_q, chain_q, st_q, st_d;
  logic         keys_ready_q, fin_q;
  logic [aescbc_pkg::KeyIdxW-1:0] widx_q;
  logic [aescbc_pkg::RoundW-1:0]  rnd_q;
  logic [7:0]   rc_q;
  logic [127:0] rk_mem [aescbc_pkg::NumRounds+1];
  logic [31:0]  win [8];
  logic [31:0]  new_w, prev_w, t_w;
  logic [127:0] rk_cur;
  logic [127:0] blk;
  logic [127:0] padded;
  logic [4:0]   cnt;
  logic         in_fire, out_fire, last_round, in_round;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == aescbc_pkg::StIdle);
  assign out_valid_o = (state_q == aescbc_pkg::StOut);
  assign in_round    = (state_q == aescbc_pkg::StRound);
  assign cipher_high_o = st_q[127:64];
  assign cipher_low_o  = st_q[63:0];
  assign last_o        = fin_q;
  assign last_round = (rnd_q == aescbc_pkg::RoundW'(aescbc_pkg::NumRounds));
  assign blk = {block_high_i, block_low_i};

  // round key for the current round, one 128-bit entry per round
  always_comb begin
    rk_cur = rk_mem[rnd_q];
  end

  // key schedule step over a window of the last eight words
  always_comb begin
    prev_w = win[7];
    if (widx_q[2:0] == 3'd0)
      t_w = aescbc_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_q, 24'd0};
    else if (widx_q[2:0] == 3'd4)
      t_w = aescbc_pkg::sub_word(prev_w);
    else
      t_w = prev_w;
    new_w = win[0] ^ t_w;
  end

  // padding
  always_comb begin
    cnt = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
    for (int i = 0; i < 16; i++)
      padded[127-8*i -: 8] = (5'(i) >= cnt) ? 8'(5'd16 - cnt) : blk[127-8*i -: 8];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      aescbc_pkg::StIdle:
        if (in_fire) begin
          st_d = padded ^ chain_q;
          state_d = keys_ready_q ? aescbc_pkg::StLoad : aescbc_pkg::StExpand;
        end
      aescbc_pkg::StExpand:
        if (widx_q == aescbc_pkg::KeyIdxW'(aescbc_pkg::NumKeyWords - 1))
          state_d = aescbc_pkg::StLoad;
      aescbc_pkg::StLoad: begin
        st_d = st_q ^ rk_cur;
        state_d = aescbc_pkg::StRound;
      end
      aescbc_pkg::StRound: begin
        st_d = aescbc_pkg::round_fn(st_q, !last_round) ^ rk_cur;
        if (last_round) state_d = aescbc_pkg::StOut;
      end
      aescbc_pkg::StOut:
        if (out_fire) state_d = aescbc_pkg::StIdle;
      default: state_d = aescbc_pkg::StIdle;
    endcase
  end

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= aescbc_pkg::StIdle;
      key_q        <= '0;
      iv_q         <= '0;
      chain_q      <= '0;
      keys_ready_q <= 1'b0;
      fin_q        <= 1'b0;
      widx_q       <= '0;
      rnd_q        <= '0;
      rc_q         <= 8'h01;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          aescbc_pkg::RegKey0: begin key_q[255:192] <= cfg_data_i; keys_ready_q <= 1'b0; end
          aescbc_pkg::RegKey1: begin key_q[191:128] <= cfg_data_i; keys_ready_q <= 1'b0; end
          aescbc_pkg::RegKey2: begin key_q[127:64]  <= cfg_data_i; keys_ready_q <= 1'b0; end
          aescbc_pkg::RegKey3: begin key_q[63:0]    <= cfg_data_i; keys_ready_q <= 1'b0; end
          aescbc_pkg::RegIvHi: begin iv_q[127:64] <= cfg_data_i; chain_q[127:64] <= cfg_data_i; end
          aescbc_pkg::RegIvLo: begin iv_q[63:0]   <= cfg_data_i; chain_q[63:0]   <= cfg_data_i; end
          default: ;
        endcase
      end
      if (in_fire) begin
        fin_q  <= (byte_count_i < 5'd16);
        widx_q <= aescbc_pkg::KeyIdxW'(8);
        rc_q   <= 8'h01;
        rnd_q  <= '0;
      end
      if (state_q == aescbc_pkg::StExpand) begin
        widx_q <= widx_q + 1'b1;
        if (widx_q[2:0] == 3'd0) rc_q <= aescbc_pkg::xtime(rc_q);
        if (state_d == aescbc_pkg::StLoad) keys_ready_q <= 1'b1;
      end
      if (state_q == aescbc_pkg::StLoad || state_q == aescbc_pkg::StRound)
        rnd_q <= rnd_q + 1'b1;
      if (state_q == aescbc_pkg::StRound && last_round)
        chain_q <= fin_q ? iv_q : st_d;
    end
  end

  // state and round key store
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (in_fire && !keys_ready_q) begin
      for (int i = 0; i < 8; i++) win[i] <= key_q[255-32*i -: 32];
      rk_mem[0] <= key_q[255:128];
      rk_mem[1] <= key_q[127:0];
    end else if (state_q == aescbc_pkg::StExpand) begin
      for (int i = 0; i < 7; i++) win[i] <= win[i+1];
      win[7] <= new_w;
      rk_mem[widx_q[5:2]][127-32*widx_q[1:0] -: 32] <= new_w;
    end
  end

  `AES_ASSERT(a_ready_excl, !(in_ready_o && out_valid_o), "ready and valid together")
  `AES_ASSERT(a_out_after_round, $rose(out_valid_o) |-> $past(in_round), "early result")
  `AES_ASSERT(a_load_keys, (state_q == aescbc_pkg::StLoad) |-> keys_ready_q || cfg_we_i, "no keys")
  `AES_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> in_ready_o || !rst_ni, "not idle after reset")

endmodule
`default_nettype wire

// File: tb/tb_aes256_cbc_encryptor.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_aes256_cbc_encryptor;

  localparam int unsigned IdleCap = 20000;

  // cipher block as seen on the output channel
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_t;

  // predicts ciphertext and keeps the blocks still owed by the encryptor
  class cbc_scoreboard;
    logic [7:0]  sbox_tbl [256];
    logic [63:0] key_q [4];
    logic [63:0] iv_hi, iv_lo;
    logic [127:0] chain;
    logic [31:0] rk [60];
    bit          rk_valid;
    cipher_t     owed [$];
    int          errors;

    function new();
      logic [7:0] p, q, x;
      // build the s-box from the field inverse and the affine map
      p = 8'h01;
      q = 8'h01;
      sbox_tbl[0] = 8'h63;
      do begin
        p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1B : 8'h00);
        q = q ^ {q[6:0], 1'b0};
        q = q ^ {q[5:0], 2'b00};
        q = q ^ {q[3:0], 4'b0000};
        if (q[7]) q = q ^ 8'h09;
        x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
        sbox_tbl[p] = x ^ 8'h63;
      end while (p != 8'h01);
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      foreach (key_q[i]) key_q[i] = '0;
      iv_hi = '0;
      iv_lo = '0;
      chain = '0;
      rk_valid = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        aescbc_pkg::RegKey0: begin key_q[0] = val; rk_valid = 0; end
        aescbc_pkg::RegKey1: begin key_q[1] = val; rk_valid = 0; end
        aescbc_pkg::RegKey2: begin key_q[2] = val; rk_valid = 0; end
        aescbc_pkg::RegKey3: begin key_q[3] = val; rk_valid = 0; end
        aescbc_pkg::RegIvHi: begin iv_hi = val; chain[127:64] = val; end
        aescbc_pkg::RegIvLo: begin iv_lo = val; chain[63:0] = val; end
        default: ;
      endcase
    endfunction

    function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function logic [31:0] sbox_word(logic [31:0] w);
      return {sbox_tbl[w[31:24]], sbox_tbl[w[23:16]], sbox_tbl[w[15:8]], sbox_tbl[w[7:0]]};
    endfunction

    function void expand_key();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) rk[i] = i[0] ? key_q[i/2][31:0] : key_q[i/2][63:32];
      for (int i = 8; i < 60; i++) begin
        t = rk[i-1];
        if (i % 8 == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = dbl(rcon);
        end else if (i % 8 == 4) begin
          t = sbox_word(t);
        end
        rk[i] = rk[i-8] ^ t;
      end
      rk_valid = 1;
    endfunction

    // note an accepted plaintext request and queue its ciphertext
    function void note_block(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt_in);
      logic [7:0]   st [16];
      logic [7:0]   tmp [16];
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] pt;
      logic [127:0] ct;
      int unsigned  cnt;
      cipher_t      res;
      cnt = (cnt_in > 16) ? 16 : cnt_in;
      if (!rk_valid) expand_key();
      pt = {bh, bl};
      for (int i = 0; i < 16; i++) begin
        st[i] = (i >= cnt) ? 8'(16 - cnt) : pt[127-8*i -: 8];
        st[i] ^= chain[127-8*i -: 8];
      end
      for (int r = 0; r <= aescbc_pkg::NumRounds; r++) begin
        if (r > 0) begin
          for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) tmp[c*4+k] = sbox_tbl[st[((c+k)%4)*4+k]];
          for (int c = 0; c < 4; c++) begin
            a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
            if (r < aescbc_pkg::NumRounds) begin
              tmp[c*4]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
              tmp[c*4+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
              tmp[c*4+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
              tmp[c*4+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
            end
          end
          st = tmp;
        end
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++) st[c*4+j] ^= rk[r*4+c][31-8*j -: 8];
      end
      for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
      res.hi = ct[127:64];
      res.lo = ct[63:0];
      res.last = (cnt < 16);
      owed.push_back(res);
      chain = res.last ? {iv_hi, iv_lo} : ct;
    endfunction

    // compare one accepted ciphertext with the oldest owed block
    function void check_cipher(cipher_t got);
      cipher_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h last %b", got.hi, got.lo, got.last);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("cipher differs: exp %h %h last %b, got %h %h last %b",
                   want.hi, want.lo, want.last, got.hi, got.lo, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic [4:0]  byte_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;
  logic        last_o;

  cbc_scoreboard sb = new();
  bit  calm;
  int  idle_cycles;

  always #2 clk_i = ~clk_i;

  aes256_cbc_encryptor i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .block_high_i, .block_low_i, .byte_count_i,
    .out_valid_o, .out_ready_i, .cipher_high_o, .cipher_low_o, .last_o
  );

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_block(block_high_i, block_low_i, byte_count_i);
      if (out_valid_o && out_ready_i) sb.check_cipher('{cipher_high_o, cipher_low_o, last_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // receiver stalls at random, except in the calm phase
  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 11);
  end

  // watchdog on cycles without progress
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleCap) begin
      $display("aes256_cbc_encryptor: mismatch");
      $finish;
    end
  end

  task automatic write_reg(aescbc_pkg::cfg_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // pauses until every owed block is back
  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_block(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 11) @(negedge clk_i);
    in_valid_i <= 1;
    block_high_i <= bh;
    block_low_i <= bl;
    byte_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 5'd16;
    if (pick < 92) return 5'($urandom_range(15));
    return 5'($urandom_range(31, 17));
  endfunction

  task automatic load_settings(bit extreme_ones);
    write_reg(aescbc_pkg::RegKey0, extreme_ones ? '1 : rand64());
    write_reg(aescbc_pkg::RegKey1, extreme_ones ? '1 : rand64());
    write_reg(aescbc_pkg::RegKey2, extreme_ones ? '1 : rand64());
    write_reg(aescbc_pkg::RegKey3, extreme_ones ? '1 : rand64());
    write_reg(aescbc_pkg::RegIvHi, extreme_ones ? '1 : rand64());
    write_reg(aescbc_pkg::RegIvLo, extreme_ones ? '1 : rand64());
  endtask

  initial begin
    calm = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // all-zero key and iv after reset, count extremes
    send_block('0, '0, 5'd16);
    send_block('1, '1, 5'd16);
    send_block('1, '1, 5'd0);
    send_block('1, '1, 5'd1);
    send_block(rand64(), rand64(), 5'd15);
    send_block(rand64(), rand64(), 5'd31);
    send_block(rand64(), rand64(), 5'd17);
    drain();

    // all-ones key and iv
    load_settings(1);
    send_block('0, '0, 5'd16);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd8);
    drain();

    // iv write in the middle of a message, bad register index ignored
    write_reg(aescbc_pkg::RegKey2, 64'h8000000000000001);
    send_block(rand64(), rand64(), 5'd16);
    drain();
    write_reg(aescbc_pkg::RegIvHi, 64'hA5A5A5A5A5A5A5A5);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= 3'd7;
    cfg_data_i <= '1;
    @(negedge clk_i);
    cfg_idx_i <= 3'd6;
    @(negedge clk_i);
    cfg_we_i <= 0;
    send_block(rand64(), rand64(), 5'd16);
    send_block(rand64(), rand64(), 5'd4);
    drain();

    // random messages, settings changed between phases
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 3);
      if (ph == 6) begin
        load_settings(0);
        write_reg(aescbc_pkg::RegKey0, '0); write_reg(aescbc_pkg::RegKey1, '0);
        write_reg(aescbc_pkg::RegKey2, '0); write_reg(aescbc_pkg::RegKey3, '0);
        write_reg(aescbc_pkg::RegIvHi, '0); write_reg(aescbc_pkg::RegIvLo, '0);
      end else begin
        load_settings(0);
      end
      for (int n = 0; n < 100; n++) send_block(rand64(), rand64(), rand_count());
      drain();
    end
    calm = 0;

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("aes256_cbc_encryptor: match");
    end else begin
      $display("aes256_cbc_encryptor: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/aescbc_pkg.sv
rtl/aes256_cbc_encryptor.sv
tb/tb_aes256_cbc_encryptor.sv
